/* sv/cba_pkg.sv */
// Shared widths, codes and types of the chained block allocator.
package cba_pkg;

   // Fixed field widths of the channel words and the control register
   localparam int OPCODE_W = 2;
   localparam int BLOCK_W  = 12;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 13;
   localparam int CSR_W    = 13;

   // Table geometry: one 4-byte entry per 256-byte storage block
   localparam int BLOCK_BYTES = 256;
   localparam int ENTRY_BYTES = 4;

   localparam logic [CSR_W-1:0] BIU_RESET = 13'd4096;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_FORMAT = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // Used-count update codes
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;
   localparam logic [1:0] CNT_ONE  = 2'd3;

   // Command from sequencer to table datapath
   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      logic [1:0] cnt_op;
   } cba_cmd_type;

endpackage

/* sv/cba_req_if.sv */
// Request channel: opcode and block word.
interface cba_req_if;
   logic                          valid;
   logic                          ready;
   logic [cba_pkg::OPCODE_W-1:0]  opcode;
   logic [cba_pkg::BLOCK_W-1:0]   block;

   modport source (output valid, output opcode, output block, input ready);
   modport sink   (input valid, input opcode, input block, output ready);
endinterface

/* sv/cba_rsp_if.sv */
// Response channel: result block, status and used count word.
interface cba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cba_pkg::BLOCK_W-1:0]   result_block;
   logic [cba_pkg::STATUS_W-1:0]  status;
   logic [cba_pkg::COUNT_W-1:0]   used_count;

   modport source (output valid, output result_block, output status, output used_count,
                   input ready);
   modport sink   (input valid, input result_block, input status, input used_count,
                   output ready);
endinterface

/* sv/chained_block_allocator.sv */
// Top level of the chained block allocator: sequencer plus table datapath.
//
//  channel   dir   handshake       word
//  --------  ----  --------------  ----------------------------------------
//  req_chan  in    valid / ready   opcode, block
//  rsp_chan  out   valid / ready   result_block, status, used_count
//  csr_*     in    csr_we          csr_wdata = blocks_in_use (13 bits)
//
// Work per word: allocate probes k entries (one table read per cycle, k up to
//   size - 1), then links the previous block if there is one and marks the
//   found entry; free walks the chain, one read and one write per entry;
//   read link does one table read; format sweeps all TABLE_ENTRIES entries;
//   a range error or a free of block 0 goes straight to the response. The
//   single table port sets all of this: every probe and clear is one memory
//   access, and a link is one read of the previous block and one write.
// Reset: synchronous. A clearing pass over all TABLE_ENTRIES entries follows
//   reset, with req_chan.ready low; csr writes are taken throughout.
// Stalls: a finished word sits in the response register while the next request
//   is accepted and worked on; only the hand-off of the next result waits on
//   rsp_chan.ready.
module chained_block_allocator #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   cba_req_if.sink                      req_chan,
   cba_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [cba_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int NW = $clog2(TABLE_ENTRIES + 1);

   // command and status between sequencer and table
   cba_pkg::cba_cmd_type  cmd;
   logic [AW-1:0]         tbl_addr;
   logic [AW:0]           tbl_wdata;
   logic [AW:0]           tbl_rd_data;
   logic [NW-1:0]         tbl_used_count;

   cba_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_opcode       (req_chan.opcode),
      .req_block        (req_chan.block),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_result_block (rsp_chan.result_block),
      .rsp_status       (rsp_chan.status),
      .rsp_used_count   (rsp_chan.used_count),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .addr             (tbl_addr),
      .wdata            (tbl_wdata),
      .rd_data          (tbl_rd_data),
      .used_count       (tbl_used_count)
   );

   // entry memory and used counter
   cba_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .addr       (tbl_addr),
      .wdata      (tbl_wdata),
      .rd_data    (tbl_rd_data),
      .used_count (tbl_used_count)
   );

endmodule

/* sv/cba_table.sv */
// Table datapath: entry memory with registered read, and the used-entry counter.
module cba_table #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cba_pkg::cba_cmd_type               cmd,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]   addr,
   input  logic [$clog2(TABLE_ENTRIES):0]     wdata,
   output logic [$clog2(TABLE_ENTRIES):0]     rd_data,
   output logic [$clog2(TABLE_ENTRIES+1)-1:0] used_count
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int NW = $clog2(TABLE_ENTRIES + 1);

   // entry = {link, used}
   logic [AW:0]   mem [TABLE_ENTRIES];
   logic [AW:0]   rd_data_ff;
   logic [NW-1:0] cnt_ff;
   logic [NW-1:0] cnt_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         cba_pkg::CNT_INC:  cnt_in = cnt_ff + NW'(1);
         cba_pkg::CNT_DEC:  cnt_in = cnt_ff - NW'(1);
         cba_pkg::CNT_ONE:  cnt_in = NW'(1);
         default:           cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rd_data    = rd_data_ff;
   assign used_count = cnt_ff;

endmodule

/* sv/cba_ctrl.sv */
// Sequencer: request decode, table scan, chain walk, sweep and response register.
module cba_ctrl #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cba_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [cba_pkg::BLOCK_W-1:0]         req_block,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cba_pkg::BLOCK_W-1:0]         rsp_result_block,
   output logic [cba_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cba_pkg::COUNT_W-1:0]         rsp_used_count,
   input  logic                                csr_we,
   input  logic [cba_pkg::CSR_W-1:0]           csr_wdata,
   output cba_pkg::cba_cmd_type                cmd,
   output logic [$clog2(TABLE_ENTRIES)-1:0]    addr,
   output logic [$clog2(TABLE_ENTRIES):0]      wdata,
   input  logic [$clog2(TABLE_ENTRIES):0]      rd_data,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0]  used_count
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int NW = $clog2(TABLE_ENTRIES + 1);
   localparam int CW = (NW > cba_pkg::CSR_W) ? NW : cba_pkg::CSR_W;
   localparam int MW = CW + 2;

   localparam logic [3:0] S_SWEEP      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_ALLOC_SCAN = 4'd2;
   localparam logic [3:0] S_ALLOC_PRD  = 4'd3;
   localparam logic [3:0] S_ALLOC_LINK = 4'd4;
   localparam logic [3:0] S_ALLOC_MARK = 4'd5;
   localparam logic [3:0] S_FREE_RD    = 4'd6;
   localparam logic [3:0] S_FREE_WR    = 4'd7;
   localparam logic [3:0] S_READ_RD    = 4'd8;
   localparam logic [3:0] S_READ_WAIT  = 4'd9;
   localparam logic [3:0] S_DONE       = 4'd10;

   logic [3:0]                     state_ff, state_in;
   logic [cba_pkg::CSR_W-1:0]      biu_ff;
   logic [AW-1:0]                  blk_ff, blk_in;
   logic [AW-1:0]                  ptr_ff, ptr_in;
   logic [CW-1:0]                  rem_ff, rem_in;
   logic                           chk_v_ff, chk_v_in;
   logic [AW-1:0]                  chk_addr_ff, chk_addr_in;
   logic [AW-1:0]                  found_ff, found_in;
   logic                           fmt_ff, fmt_in;
   logic [cba_pkg::BLOCK_W-1:0]    res_ff, res_in;
   logic [cba_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cba_pkg::BLOCK_W-1:0]    rsp_block_ff;
   logic [cba_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [cba_pkg::COUNT_W-1:0]    rsp_count_ff;
   logic                           rsp_load;

   logic [CW-1:0]                  biu_ext;
   logic [CW-1:0]                  size;
   logic [MW-1:0]                  size_bytes;
   logic [CW-1:0]                  maps;
   logic [CW-1:0]                  blk_ext;
   logic [AW-1:0]                  blk_idx;
   logic [AW-1:0]                  rd_link;
   logic [CW-1:0]                  rd_link_ext;
   logic [CW-1:0]                  chk_addr_ext;
   logic [CW-1:0]                  ptr_ext;
   logic [CW-1:0]                  cnt_ext;
   logic                           fmt_used;

   // next scan position, wrapping at the table size
   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                              input logic [CW-1:0] lim);
      logic [CW-1:0] p1;
      p1 = CW'(p) + CW'(1);
      if (p1 == lim) begin
         next_pos = '0;
      end else begin
         next_pos = p + AW'(1);
      end
   endfunction

   // effective table size: register clamped to [2, TABLE_ENTRIES]
   assign biu_ext = CW'(biu_ff);
   always_comb begin
      if (biu_ext < CW'(2)) begin
         size = CW'(2);
      end else if (biu_ext > CW'(TABLE_ENTRIES)) begin
         size = CW'(TABLE_ENTRIES);
      end else begin
         size = biu_ext;
      end
   end

   assign size_bytes   = MW'(size) * MW'(cba_pkg::ENTRY_BYTES);
   assign maps         = CW'(size_bytes / cba_pkg::BLOCK_BYTES);
   assign blk_ext      = CW'(req_block);
   assign blk_idx      = blk_ext[AW-1:0];
   assign rd_link      = rd_data[AW:1];
   assign rd_link_ext  = CW'(rd_link);
   assign chk_addr_ext = CW'(chk_addr_ff);
   assign ptr_ext      = CW'(ptr_ff);
   assign cnt_ext      = CW'(used_count);
   assign fmt_used     = fmt_ff && ((ptr_ff == '0) || (ptr_ext <= maps));

   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      chk_v_in     = chk_v_ff;
      chk_addr_in  = chk_addr_ff;
      found_in     = found_ff;
      fmt_in       = fmt_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_load     = 1'b0;
      req_ready    = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.wr_en    = 1'b0;
      cmd.cnt_op   = cba_pkg::CNT_HOLD;
      addr         = ptr_ff;
      wdata        = '0;

      case (state_ff)
         S_SWEEP: begin
            cmd.wr_en = 1'b1;
            wdata     = {{AW{1'b0}}, fmt_used};
            if (fmt_ff && (ptr_ff == '0)) begin
               cmd.cnt_op = cba_pkg::CNT_ONE;
            end else if (fmt_used) begin
               cmd.cnt_op = cba_pkg::CNT_INC;
            end
            if (ptr_ff == AW'(TABLE_ENTRIES - 1)) begin
               state_in = fmt_ff ? S_DONE : S_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in    = '0;
               status_in = cba_pkg::ST_OK;
               case (req_opcode)
                  cba_pkg::OP_ALLOC: begin
                     if (blk_ext >= size) begin
                        status_in = cba_pkg::ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        blk_in   = blk_idx;
                        ptr_in   = next_pos(blk_idx, size);
                        rem_in   = size - CW'(1);
                        chk_v_in = 1'b0;
                        state_in = S_ALLOC_SCAN;
                     end
                  end
                  cba_pkg::OP_FREE: begin
                     if (blk_ext == '0) begin
                        state_in = S_DONE;
                     end else if (blk_ext >= size) begin
                        status_in = cba_pkg::ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        ptr_in   = blk_idx;
                        state_in = S_FREE_RD;
                     end
                  end
                  cba_pkg::OP_READ: begin
                     if (blk_ext >= size) begin
                        status_in = cba_pkg::ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        blk_in   = blk_idx;
                        state_in = S_READ_RD;
                     end
                  end
                  default: begin
                     ptr_in   = '0;
                     fmt_in   = 1'b1;
                     state_in = S_SWEEP;
                  end
               endcase
            end
         end

         // one probe issued per cycle; its data is checked in the next cycle
         S_ALLOC_SCAN: begin
            cmd.rd_en   = (rem_ff != '0);
            chk_v_in    = (rem_ff != '0);
            chk_addr_in = ptr_ff;
            if (rem_ff != '0) begin
               ptr_in = next_pos(ptr_ff, size);
               rem_in = rem_ff - CW'(1);
            end
            if (chk_v_ff && (rd_data == '0)) begin
               found_in = chk_addr_ff;
               res_in   = chk_addr_ext[cba_pkg::BLOCK_W-1:0];
               state_in = (blk_ff != '0) ? S_ALLOC_PRD : S_ALLOC_MARK;
            end else if (chk_v_ff && (rem_ff == '0)) begin
               status_in = cba_pkg::ST_FULL;
               state_in  = S_DONE;
            end
         end

         S_ALLOC_PRD: begin
            cmd.rd_en = 1'b1;
            addr      = blk_ff;
            state_in  = S_ALLOC_LINK;
         end

         S_ALLOC_LINK: begin
            cmd.wr_en  = 1'b1;
            addr       = blk_ff;
            wdata      = {found_ff, 1'b1};
            cmd.cnt_op = rd_data[0] ? cba_pkg::CNT_HOLD : cba_pkg::CNT_INC;
            state_in   = S_ALLOC_MARK;
         end

         S_ALLOC_MARK: begin
            cmd.wr_en  = 1'b1;
            addr       = found_ff;
            wdata      = {{AW{1'b0}}, 1'b1};
            cmd.cnt_op = cba_pkg::CNT_INC;
            state_in   = S_DONE;
         end

         S_FREE_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_FREE_WR;
         end

         S_FREE_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.cnt_op = rd_data[0] ? cba_pkg::CNT_DEC : cba_pkg::CNT_HOLD;
            if (rd_link == '0) begin
               state_in = S_DONE;
            end else if (rd_link_ext >= size) begin
               status_in = cba_pkg::ST_RANGE;
               state_in  = S_DONE;
            end else begin
               ptr_in   = rd_link;
               state_in = S_FREE_RD;
            end
         end

         S_READ_RD: begin
            cmd.rd_en = 1'b1;
            addr      = blk_ff;
            state_in  = S_READ_WAIT;
         end

         S_READ_WAIT: begin
            res_in   = rd_link_ext[cba_pkg::BLOCK_W-1:0];
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               fmt_in   = 1'b0;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         ptr_ff       <= '0;
         fmt_ff       <= 1'b0;
         chk_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         biu_ff       <= cba_pkg::BIU_RESET;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fmt_ff       <= fmt_in;
         chk_v_ff     <= chk_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            biu_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      rem_ff      <= rem_in;
      chk_addr_ff <= chk_addr_in;
      found_ff    <= found_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      if (rsp_load) begin
         rsp_block_ff  <= res_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= cnt_ext[cba_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_used_count   = rsp_count_ff;

endmodule
